### rtl/lphm_pkg.sv
// Package for the linear probing hash map: command and status codes, FSM state type.
// No dependencies.
`timescale 1ns / 1ps
package lphm_pkg;
  typedef enum logic [1:0] {
    CMD_INSERT     = 2'd0,
    CMD_LOOKUP     = 2'd1,
    CMD_REMOVE_KEY = 2'd2,
    CMD_REMOVE_AT  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_FULL      = 3'd5,
    ST_REJECTED  = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_PROBE,
    S_SHIFT,
    S_DONE
  } state_e;

  localparam logic [63:0] EmptyKey = 64'hFFFF_FFFF_FFFF_FFFF;
endpackage

### rtl/linear_probe_hash_map.sv
// Linear probing hash map top level: key and payload memories plus the command sequencer.
// Depends on lphm_pkg.
//
// After reset the block sweeps the key memory to empty, one slot a cycle, with busy_o high.
// A command is taken when start_i is high and busy_o low. Each probe or shift step reads
// one slot from the synchronous key and payload memories in an address phase followed by
// a registered-data phase; a removal then goes on scanning the following slots up to the
// next empty slot, moving entries back into the hole where their home slot allows. The
// result shows for one cycle with done_o high and cannot be stalled.
`timescale 1ns / 1ps
module linear_probe_hash_map #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  cmd_i,
  input  logic [63:0] key_in_i,
  input  logic [63:0] payload_in_i,
  input  logic [9:0]  slot_in_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [63:0] payload_out_o,
  output logic [9:0]  slot_out_o,
  output logic [10:0] entry_count_o
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [AW:0] DepthW = (AW + 1)'(TABLE_DEPTH);

  logic [63:0] key_mem [TABLE_DEPTH];
  logic [63:0] pay_mem [TABLE_DEPTH];

  lphm_pkg::state_e state_q, state_d;
  logic          phase_q, phase_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic [AW-1:0] hole_q, hole_d;
  logic [1:0]    cmd_q, cmd_d;
  logic [63:0]   key_q, key_d;
  logic [63:0]   pay_q, pay_d;
  logic [CW-1:0] live_q, live_d;
  logic [2:0]    st_q, st_d;
  logic [63:0]   pout_q, pout_d;
  logic [9:0]    sout_q, sout_d;

  logic          we;
  logic [AW-1:0] wa;
  logic [63:0]   wk, wp;
  logic          pwe;
  logic [63:0]   rk_q, rp_q;

  always_ff @(posedge clk_i) begin
    if (we) key_mem[wa] <= wk;
    if (pwe) pay_mem[wa] <= wp;
    rk_q <= key_mem[addr_d];
    rp_q <= pay_mem[addr_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lphm_pkg::S_CLEAR;
      phase_q <= 1'b0;
      addr_q  <= '0;
      cnt_q   <= '0;
      hole_q  <= '0;
      cmd_q   <= '0;
      live_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      addr_q  <= addr_d;
      cnt_q   <= cnt_d;
      hole_q  <= hole_d;
      cmd_q   <= cmd_d;
      live_q  <= live_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    pay_q  <= pay_d;
    st_q   <= st_d;
    pout_q <= pout_d;
    sout_q <= sout_d;
  end

  logic [AW-1:0] nxt;
  logic [AW-1:0] home_k, home_r;
  logic [AW-1:0] d_hole, d_j;
  always_comb begin
    nxt    = (addr_q == AW'(TABLE_DEPTH - 1)) ? '0 : addr_q + 1'b1;
    home_k = key_in_i[AW-1:0];
    home_r = rk_q[AW-1:0];
    d_hole = hole_q - home_r;
    d_j    = addr_q - home_r;
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    addr_d  = addr_q;
    cnt_d   = cnt_q;
    hole_d  = hole_q;
    cmd_d   = cmd_q;
    key_d   = key_q;
    pay_d   = pay_q;
    live_d  = live_q;
    st_d    = st_q;
    pout_d  = pout_q;
    sout_d  = sout_q;
    we      = 1'b0;
    pwe     = 1'b0;
    wa      = addr_q;
    wk      = lphm_pkg::EmptyKey;
    wp      = rp_q;
    unique case (state_q)
      lphm_pkg::S_CLEAR: begin
        we = 1'b1;
        addr_d = nxt;
        if (addr_q == AW'(TABLE_DEPTH - 1)) state_d = lphm_pkg::S_IDLE;
      end
      lphm_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_d  = cmd_i;
          key_d  = key_in_i;
          pay_d  = payload_in_i;
          pout_d = '0;
          sout_d = '0;
          cnt_d  = '0;
          phase_d = 1'b0;
          if (cmd_i != lphm_pkg::CMD_REMOVE_AT && key_in_i == lphm_pkg::EmptyKey) begin
            st_d = lphm_pkg::ST_REJECTED;
            state_d = lphm_pkg::S_DONE;
          end else if (cmd_i == lphm_pkg::CMD_REMOVE_AT) begin
            sout_d = slot_in_i;
            st_d = lphm_pkg::ST_NOT_FOUND;
            if (32'(slot_in_i) < 32'(TABLE_DEPTH)) begin
              addr_d = AW'(slot_in_i);
              state_d = lphm_pkg::S_PROBE;
            end else begin
              state_d = lphm_pkg::S_DONE;
            end
          end else begin
            addr_d = home_k;
            state_d = lphm_pkg::S_PROBE;
          end
        end
      end
      lphm_pkg::S_PROBE: begin
        if (!phase_q) begin
          phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          if (cmd_q == lphm_pkg::CMD_REMOVE_AT) begin
            if (rk_q == lphm_pkg::EmptyKey) begin
              state_d = lphm_pkg::S_DONE;
            end else begin
              pout_d = rp_q;
              st_d = lphm_pkg::ST_REMOVED;
              hole_d = addr_q;
              addr_d = nxt;
              state_d = lphm_pkg::S_SHIFT;
            end
          end else if (rk_q == lphm_pkg::EmptyKey) begin
            if (cmd_q == lphm_pkg::CMD_INSERT) begin
              we = 1'b1;
              pwe = 1'b1;
              wk = key_q;
              wp = pay_q;
              live_d = live_q + 1'b1;
              st_d = lphm_pkg::ST_INSERTED;
              sout_d = 10'(addr_q);
            end else begin
              st_d = lphm_pkg::ST_NOT_FOUND;
            end
            state_d = lphm_pkg::S_DONE;
          end else if (rk_q == key_q) begin
            pout_d = rp_q;
            sout_d = 10'(addr_q);
            priority case (cmd_q)
              lphm_pkg::CMD_INSERT: begin
                st_d = lphm_pkg::ST_DUPLICATE;
                state_d = lphm_pkg::S_DONE;
              end
              lphm_pkg::CMD_LOOKUP: begin
                st_d = lphm_pkg::ST_FOUND;
                state_d = lphm_pkg::S_DONE;
              end
              default: begin
                st_d = lphm_pkg::ST_REMOVED;
                hole_d = addr_q;
                addr_d = nxt;
                state_d = lphm_pkg::S_SHIFT;
              end
            endcase
          end else if (cnt_q == DepthW - 1'b1) begin
            st_d = (cmd_q == lphm_pkg::CMD_INSERT) ? lphm_pkg::ST_FULL
                                                   : lphm_pkg::ST_NOT_FOUND;
            sout_d = '0;
            state_d = lphm_pkg::S_DONE;
          end else begin
            cnt_d = cnt_q + 1'b1;
            addr_d = nxt;
          end
        end
      end
      lphm_pkg::S_SHIFT: begin
        if (!phase_q) begin
          phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          if (addr_q == hole_q || rk_q == lphm_pkg::EmptyKey) begin
            we = 1'b1;
            wa = hole_q;
            wk = lphm_pkg::EmptyKey;
            if (live_q != '0) live_d = live_q - 1'b1;
            state_d = lphm_pkg::S_DONE;
          end else begin
            if (d_hole < d_j) begin
              we = 1'b1;
              pwe = 1'b1;
              wa = hole_q;
              wk = rk_q;
              wp = rp_q;
              hole_d = addr_q;
            end
            addr_d = nxt;
          end
        end
      end
      lphm_pkg::S_DONE: begin
        state_d = lphm_pkg::S_IDLE;
      end
      default: state_d = lphm_pkg::S_IDLE;
    endcase
  end

  assign busy_o        = (state_q != lphm_pkg::S_IDLE);
  assign done_o        = (state_q == lphm_pkg::S_DONE);
  assign status_o      = st_q;
  assign payload_out_o = pout_q;
  assign slot_out_o    = sout_q;
  assign entry_count_o = 11'(live_q);

  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_live_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CW'(TABLE_DEPTH)) else $error("count overflow");
  a_ins_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == lphm_pkg::ST_INSERTED) |-> live_q == $past(live_q, 2) + 1'b1)
    else $error("insert count");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o) else $error("done not followed by idle");
endmodule
